// ===== hdl/bcp_pkg.sv =====
// shared constants for the black-76 option pricer
`default_nettype none

package bcp_pkg;

  // Q.28 fixed-point constants
  localparam int ONE_Q28     = 268435456;
  localparam int LN2_Q28     = 186065280;
  localparam int INV_SQRT2PI = 107090253;

  // abramowitz-stegun 26.2.17 coefficients, Q.28
  localparam int AS_P = 62180899;
  localparam int AS_B [1:5] = '{85733327, -95714361, 478211842, -488889679, 357092823};

  // lower bound of sigma*sqrt(t) and limit of d1, d2, both Q.24
  localparam int DS_MIN_Q24 = 17;
  localparam int D_LIM_Q24  = 134217728;

  // floor(2^40 / ln2 in Q.28), for splitting u into n*ln2 + r
  localparam int LN2_RECIP       = 5909;
  localparam int LN2_RECIP_SHIFT = 40;

  // exp(-r) series length and floor(2^32 / k) for each term
  localparam int EXP_TERMS = 12;
  localparam logic [32:0] EXP_RECIP [1:12] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
  };

  // pipeline depth of the normal-tail unit
  localparam int TAIL_LAT = 43;

endpackage

`default_nettype wire

// ===== hdl/bcp_tail.sv =====
// pipelined upper tail of the standard normal distribution, input |x| in Q.28
`default_nettype none

module bcp_tail (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a_i,
  output logic [28:0] tail_o
);
  import bcp_pkg::*;

  localparam int LONG_STEPS = 3 * EXP_TERMS;
  localparam int TDIV_STEPS = 29;
  localparam int POLY_START = TDIV_STEPS;

  typedef struct packed {
    logic [27:0]        r;
    logic [5:0]         n;
    logic [28:0]        t;
    logic [27:0]        x;
    logic [27:0]        qe;
    logic [29:0]        den;
    logic [29:0]        rem;
    logic [28:0]        td;
    logic signed [33:0] acc;
    logic signed [33:0] poly;
  } lg_t;

  function automatic logic signed [33:0] mul_q28(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b);
    return p[61:28];
  endfunction

  logic [62:0] sq_r;
  logic [56:0] pa_r;
  logic [33:0] u_r, u3_r;
  logic [29:0] den_r, den3_r;
  logic [5:0]  nq_r;
  logic [46:0] nprod;
  lg_t         lg_nxt0;
  lg_t         lg_r [0:LONG_STEPS];
  logic [33:0] r0;
  logic [28:0] e_r;
  logic signed [33:0] poly1_r, poly2_r;
  logic [26:0] pdf_r;
  logic [55:0] pdf_prod;
  logic signed [33:0] tail_s;

  // a^2 and p*a
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= 63'(a_i) * 63'(a_i);
      pa_r <= 57'(a_i) * 57'(AS_P);
    end
  end

  // u = a^2/2, denominator 1 + p*a
  always_ff @(posedge clk) begin
    if (en) begin
      u_r   <= sq_r[62:29];
      den_r <= 30'(ONE_Q28) + 30'(pa_r[56:28]);
    end
  end

  // estimate of n = u / ln2
  assign nprod = 47'(u_r) * 47'(LN2_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      nq_r   <= 6'(nprod >> LN2_RECIP_SHIFT);
      u3_r   <= u_r;
      den3_r <= den_r;
    end
  end

  // exact n and remainder r, seed of both iterations
  always_comb begin
    r0      = u3_r - 34'(nq_r) * 34'(LN2_Q28);
    lg_nxt0 = '0;
    if (r0 >= 34'(LN2_Q28)) begin
      lg_nxt0.r = 28'(r0 - 34'(LN2_Q28));
      lg_nxt0.n = nq_r + 6'd1;
    end else begin
      lg_nxt0.r = r0[27:0];
      lg_nxt0.n = nq_r;
    end
    lg_nxt0.t   = 29'(ONE_Q28);
    lg_nxt0.den = den3_r;
    lg_nxt0.rem = 30'd1 << 27;
    lg_nxt0.td  = '0;
    lg_nxt0.acc = 34'(AS_B[5]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_r[0] <= lg_nxt0;
    end
  end

  // horner series of exp(-r), three stages a term, with 1/(1+p*a) and
  // the rational polynomial running alongside
  for (genvar s = 1; s <= LONG_STEPS; s++) begin : g_long
    localparam int S0 = s - 1;
    localparam int K  = EXP_TERMS - S0 / 3;
    localparam int PH = S0 % 3;
    localparam int B  = (S0 < TDIV_STEPS) ? TDIV_STEPS - 1 - S0 : 0;
    localparam int C  = (S0 >= POLY_START && S0 < POLY_START + 4) ? POLY_START + 4 - S0 : 1;
    lg_t         lg_nxt;
    logic [56:0] rt;
    logic [60:0] xr;
    logic [32:0] rm;
    logic [30:0] rem2;

    always_comb begin
      lg_nxt = lg_r[s-1];
      rt     = 57'(lg_r[s-1].r) * 57'(lg_r[s-1].t);
      xr     = 61'(lg_r[s-1].x) * 61'(EXP_RECIP[K]);
      rm     = 33'(lg_r[s-1].x) - 33'(lg_r[s-1].qe) * 33'(K);
      rem2   = {lg_r[s-1].rem, 1'b0};
      if (PH == 0) begin
        lg_nxt.x = 28'(rt >> 28);
      end else if (PH == 1) begin
        lg_nxt.qe = 28'(xr >> 32);
      end else begin
        if (rm >= 33'(K)) begin
          lg_nxt.t = 29'(ONE_Q28) - 29'(lg_r[s-1].qe + 28'd1);
        end else begin
          lg_nxt.t = 29'(ONE_Q28) - 29'(lg_r[s-1].qe);
        end
      end
      if (S0 < TDIV_STEPS) begin
        if (rem2 >= {1'b0, lg_r[s-1].den}) begin
          lg_nxt.rem   = 30'(rem2 - {1'b0, lg_r[s-1].den});
          lg_nxt.td[B] = 1'b1;
        end else begin
          lg_nxt.rem = rem2[29:0];
        end
      end else if (S0 < POLY_START + 4) begin
        lg_nxt.acc = 34'(AS_B[C]) +
                     mul_q28(lg_r[s-1].acc, 34'($signed({1'b0, lg_r[s-1].td})));
      end else if (S0 == POLY_START + 4) begin
        lg_nxt.poly = mul_q28(lg_r[s-1].acc, 34'($signed({1'b0, lg_r[s-1].td})));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lg_r[s] <= lg_nxt;
      end
    end
  end

  // exp(-u) = exp(-r) / 2^n, then density and tail
  assign pdf_prod = 56'(e_r) * 56'(INV_SQRT2PI);
  assign tail_s   = mul_q28(34'($signed({1'b0, pdf_r})), poly2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      e_r     <= lg_r[LONG_STEPS].t >> lg_r[LONG_STEPS].n;
      poly1_r <= lg_r[LONG_STEPS].poly;
      pdf_r   <= 27'(pdf_prod >> 28);
      poly2_r <= poly1_r;
      if (tail_s < 0) begin
        tail_o <= '0;
      end else if (tail_s > 34'(ONE_Q28)) begin
        tail_o <= 29'(ONE_Q28);
      end else begin
        tail_o <= tail_s[28:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/black76_option_price.sv =====
// top level of the black-76 option pricer
`default_nettype none

// Undiscounted European option price by Black's formula, one option per item:
// call = F*N(d1) - K*N(d2), put = K*N(-d2) - F*N(-d1), clamped at zero.
// Strike, forward and price are unsigned Q16.16, expiry Q8.24 years and
// volatility Q4.28. A new item can be accepted on every clock cycle unless
// the pipeline is halted; each result passes 130 pipeline stages and then
// the output register. The depth comes from the bit-per-stage square
// root and log2 (28 stages), the 53-stage d2 division and the 43-stage
// normal-tail unit, two of which run side by side for d1 and d2. The whole
// pipeline moves together and halts only when its last stage holds an item
// the output register cannot yet take; while a result waits, items enter
// until that stage is filled. A zero strike or forward takes a fixed answer.

module black76_option_price (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // strike, expiry_years, forward_price, volatility
  input  logic         in_tuser,   // mode (0 put, 1 call)
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // price
);
  import bcp_pkg::*;

  localparam int ROOT_STEPS = 28;
  localparam int DIV_STEPS  = 53;
  localparam int STG_D2     = ROOT_STEPS + 2 + DIV_STEPS + 2;
  localparam int STG_TAIL   = STG_D2 + TAIL_LAT;
  localparam int LAT        = STG_TAIL + 2;

  typedef struct packed {
    logic [55:0] v;
    logic [55:0] res;
    logic [31:0] mf;
    logic [31:0] mk;
    logic [4:0]  pf;
    logic [4:0]  pk;
    logic [27:0] ff;
    logic [27:0] fk;
    logic [31:0] sig;
  } root_t;

  typedef struct packed {
    logic [31:0] ds;
    logic [28:0] mag;
    logic        neg;
    logic [31:0] rem;
    logic [52:0] q;
  } dv_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] k;
    logic [31:0] f;
  } side_t;

  typedef struct packed {
    logic d1_ge;
    logic d1_le;
    logic d2_ge;
    logic d2_le;
  } sgn_t;

  // leading-one position and normalized mantissa of a raw value
  function automatic logic [36:0] lead_norm(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        p = 5'(i);
      end
    end
    return {p, x << (5'd31 - p)};
  endfunction

  function automatic logic signed [28:0] sat_d(input logic signed [54:0] d);
    if (d > 55'(D_LIM_Q24)) begin
      return 29'(D_LIM_Q24);
    end else if (d < -55'(D_LIM_Q24)) begin
      return -29'(D_LIM_Q24);
    end
    return d[28:0];
  endfunction

  logic            en;
  logic [LAT-1:0]  vld_r;
  logic            out_tvalid_r;
  logic [31:0]     out_tdata_r;
  side_t           side_r [0:STG_TAIL];
  sgn_t            sgn_r  [0:TAIL_LAT];

  // pipeline advances unless the last stage is blocked by a full output
  assign en        = !vld_r[LAT-1] || !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{mode: in_tuser, k: in_tdata[31:0], f: in_tdata[95:64]};
      for (int i = 1; i <= STG_TAIL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // stage 0: normalize forward and strike for log2, load sqrt operand
  root_t       root_r [0:ROOT_STEPS];
  root_t       root_nxt0;
  logic [36:0] norm_f, norm_k;

  always_comb begin
    norm_f        = lead_norm(in_tdata[95:64]);
    norm_k        = lead_norm(in_tdata[31:0]);
    root_nxt0.v   = {in_tdata[63:32], 24'd0};
    root_nxt0.res = '0;
    root_nxt0.pf  = norm_f[36:32];
    root_nxt0.mf  = norm_f[31:0];
    root_nxt0.pk  = norm_k[36:32];
    root_nxt0.mk  = norm_k[31:0];
    root_nxt0.ff  = '0;
    root_nxt0.fk  = '0;
    root_nxt0.sig = in_tdata[127:96];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r[0] <= root_nxt0;
    end
  end

  // one square-root bit and one log2 fraction bit (by squaring) a stage
  for (genvar j = 1; j <= ROOT_STEPS; j++) begin : g_root
    localparam int BITPOS = 54 - 2 * (j - 1);
    root_t       root_nxt;
    logic [56:0] sum;
    logic [63:0] sqf, sqk;

    always_comb begin
      root_nxt = root_r[j-1];
      sum      = {1'b0, root_r[j-1].res} + (57'd1 << BITPOS);
      if ({1'b0, root_r[j-1].v} >= sum) begin
        root_nxt.v   = root_r[j-1].v - sum[55:0];
        root_nxt.res = (root_r[j-1].res >> 1) + (56'd1 << BITPOS);
      end else begin
        root_nxt.res = root_r[j-1].res >> 1;
      end
      sqf = 64'(root_r[j-1].mf) * 64'(root_r[j-1].mf);
      sqk = 64'(root_r[j-1].mk) * 64'(root_r[j-1].mk);
      if (sqf[63]) begin
        root_nxt.mf = sqf[63:32];
        root_nxt.ff = {root_r[j-1].ff[26:0], 1'b1};
      end else begin
        root_nxt.mf = sqf[62:31];
        root_nxt.ff = {root_r[j-1].ff[26:0], 1'b0};
      end
      if (sqk[63]) begin
        root_nxt.mk = sqk[63:32];
        root_nxt.fk = {root_r[j-1].fk[26:0], 1'b1};
      end else begin
        root_nxt.mk = sqk[62:31];
        root_nxt.fk = {root_r[j-1].fk[26:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= root_nxt;
      end
    end
  end

  // sigma*sqrt(t) and ln(f/k) = (log2 f - log2 k) * ln2
  logic [59:0]        ds_prod;
  logic signed [33:0] dlog;
  logic [31:0]        c1_ds_r;
  logic signed [62:0] c1_lnp_r;

  assign ds_prod = 60'(root_r[ROOT_STEPS].sig) * 60'(root_r[ROOT_STEPS].res[27:0]);
  assign dlog    = $signed({1'b0, root_r[ROOT_STEPS].pf, root_r[ROOT_STEPS].ff}) -
                   $signed({1'b0, root_r[ROOT_STEPS].pk, root_r[ROOT_STEPS].fk});

  always_ff @(posedge clk) begin
    if (en) begin
      c1_ds_r  <= ds_prod[59:28];
      c1_lnp_r <= 63'(dlog) * 63'(LN2_Q28);
    end
  end

  // floor ds, split ln into sign and magnitude for the divider
  dv_t                dv_r [0:DIV_STEPS];
  dv_t                dv_nxt0;
  logic signed [30:0] ln_s;
  logic [30:0]        ln_abs;

  always_comb begin
    ln_s         = c1_lnp_r[62:32];
    ln_abs       = ln_s[30] ? 31'(-ln_s) : 31'(ln_s);
    dv_nxt0.ds   = (c1_ds_r < 32'(DS_MIN_Q24)) ? 32'(DS_MIN_Q24) : c1_ds_r;
    dv_nxt0.mag  = ln_abs[28:0];
    dv_nxt0.neg  = ln_s[30];
    dv_nxt0.rem  = '0;
    dv_nxt0.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_nxt0;
    end
  end

  // restoring division |ln|*2^24 / ds, one quotient bit a stage
  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
    localparam int B  = DIV_STEPS - i;
    localparam int MB = (B >= 24) ? B - 24 : 0;
    dv_t         dv_nxt;
    logic        nbit;
    logic [32:0] rem2;

    always_comb begin
      dv_nxt = dv_r[i-1];
      nbit   = (B >= 24) ? dv_r[i-1].mag[MB] : 1'b0;
      rem2   = {dv_r[i-1].rem, nbit};
      if (rem2 >= {1'b0, dv_r[i-1].ds}) begin
        dv_nxt.rem  = 32'(rem2 - {1'b0, dv_r[i-1].ds});
        dv_nxt.q[B] = 1'b1;
      end else begin
        dv_nxt.rem = rem2[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[i] <= dv_nxt;
      end
    end
  end

  // d2 = ln/ds - ds/2
  logic signed [54:0] q_s;
  logic signed [54:0] d2raw_r;
  logic [31:0]        ds1_r;

  assign q_s = dv_r[DIV_STEPS].neg ? -$signed({2'b00, dv_r[DIV_STEPS].q})
                                   :  $signed({2'b00, dv_r[DIV_STEPS].q});

  always_ff @(posedge clk) begin
    if (en) begin
      d2raw_r <= q_s - $signed({24'd0, dv_r[DIV_STEPS].ds[31:1]});
      ds1_r   <= dv_r[DIV_STEPS].ds;
    end
  end

  // d1 = d2 + ds, both limited to +-8, magnitudes into the tail units
  logic signed [28:0] d1c, d2c;
  logic [28:0]        d1_abs, d2_abs;
  logic [31:0]        a1_r, a2_r;

  always_comb begin
    d1c    = sat_d(d2raw_r + $signed({23'd0, ds1_r}));
    d2c    = sat_d(d2raw_r);
    d1_abs = d1c[28] ? 29'(-d1c) : 29'(d1c);
    d2_abs = d2c[28] ? 29'(-d2c) : 29'(d2c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r      <= {d1_abs[27:0], 4'd0};
      a2_r      <= {d2_abs[27:0], 4'd0};
      sgn_r[0]  <= '{d1_ge: !d1c[28], d1_le: d1c[28] || (d1c == '0),
                     d2_ge: !d2c[28], d2_le: d2c[28] || (d2c == '0)};
      for (int i = 1; i <= TAIL_LAT; i++) begin
        sgn_r[i] <= sgn_r[i-1];
      end
    end
  end

  logic [28:0] tail1, tail2;

  bcp_tail u_tail_d1 (
    .clk    (clk),
    .en     (en),
    .a_i    (a1_r),
    .tail_o (tail1)
  );

  bcp_tail u_tail_d2 (
    .clk    (clk),
    .en     (en),
    .a_i    (a2_r),
    .tail_o (tail2)
  );

  // pick the cdf values and weight them by forward and strike
  side_t       sd;
  sgn_t        sg;
  logic [28:0] n1, n2;
  logic [31:0] x1, x2;
  logic [60:0] prod1, prod2;
  logic [31:0] p1_r, p2_r;
  side_t       h_side_r;

  always_comb begin
    sd = side_r[STG_TAIL];
    sg = sgn_r[TAIL_LAT];
    if (sd.mode) begin
      x1 = sd.f;
      x2 = sd.k;
      n1 = sg.d1_ge ? 29'(ONE_Q28) - tail1 : tail1;
      n2 = sg.d2_ge ? 29'(ONE_Q28) - tail2 : tail2;
    end else begin
      x1 = sd.k;
      x2 = sd.f;
      n1 = sg.d2_le ? 29'(ONE_Q28) - tail2 : tail2;
      n2 = sg.d1_le ? 29'(ONE_Q28) - tail1 : tail1;
    end
    prod1 = 61'(x1) * 61'(n1);
    prod2 = 61'(x2) * 61'(n2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= 32'(prod1 >> 28);
      p2_r     <= 32'(prod2 >> 28);
      h_side_r <= sd;
    end
  end

  // difference, clamp at zero, fixed answers for zero strike or forward
  logic signed [32:0] diff;
  logic [31:0]        price_nxt;

  always_comb begin
    diff = $signed({1'b0, p1_r}) - $signed({1'b0, p2_r});
    if (h_side_r.k == '0) begin
      price_nxt = h_side_r.mode ? h_side_r.f : '0;
    end else if (h_side_r.f == '0) begin
      price_nxt = h_side_r.mode ? '0 : h_side_r.k;
    end else if (diff[32]) begin
      price_nxt = '0;
    end else begin
      price_nxt = diff[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (!out_tvalid_r || out_tready) begin
      out_tvalid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_tvalid_r || out_tready) begin
      out_tdata_r <= price_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire
